@@ hw/rtl/lef_pkg.sv @@
package lef_pkg;

    // largest supported row length and derived line buffer address width
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // frame geometry widths
    localparam int FW_W  = 11;
    localparam int FH_W  = 12;
    localparam int ROW_W = FH_W + 1;
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = FH_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(300);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(200);
    localparam logic [FW_W-1:0] MIN_WIDTH        = FW_W'(3);
    localparam logic [FW_W-1:0] MAX_WIDTH_V      = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] MIN_HEIGHT       = FH_W'(3);

    // item kinds on the input tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // position info for one item entering the filter pipeline
    typedef struct packed {
        logic              res;     // item releases a result
        logic              border;  // result pixel lies on the frame border
        logic              last;    // result pixel ends the frame
        logic [ADDR_W-1:0] col;     // line buffer column
    } pos_info_t;

    // 4*centre minus four neighbors, clamped to 0..255
    function automatic logic [CH_W-1:0] lap_chan(
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] n,
        input logic [CH_W-1:0] s,
        input logic [CH_W-1:0] w,
        input logic [CH_W-1:0] e
    );
        logic signed [CH_W+2:0] v;
        logic [CH_W-1:0]        r;
        v = $signed({1'b0, c, 2'b00}) - $signed({3'b000, n}) - $signed({3'b000, s})
          - $signed({3'b000, w}) - $signed({3'b000, e});
        if (v < 0) begin
            r = '0;
        end else if (v > $signed((CH_W+3)'(255))) begin
            r = '1;
        end else begin
            r = v[CH_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/lef_pos_ctrl.sv @@
module lef_pos_ctrl
    import lef_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_acc,
    input  logic                  item_kind,
    output logic                  item_enter,
    output logic                  item_zero,
    output pos_info_t             info
);

    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic              primed_reg, primed_next;

    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic              in_frame;
    logic [ADDR_W-1:0] c;
    logic [FW_W-1:0]   c_inc;
    logic [ROW_W-1:0]  orow;
    logic [ADDR_W-1:0] ocol;
    logic              res;
    logic              last;

    // effective frame geometry
    always_comb begin
        if (frame_width_reg < MIN_WIDTH) begin
            w_eff = MIN_WIDTH;
        end else if (frame_width_reg > MAX_WIDTH_V) begin
            w_eff = MAX_WIDTH_V;
        end else begin
            w_eff = frame_width_reg;
        end
        h_eff = (frame_height_reg < MIN_HEIGHT) ? MIN_HEIGHT : frame_height_reg;
    end

    // position of the result released by this item
    always_comb begin
        in_frame = row_reg < {1'b0, h_eff};
        c        = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        if (c != '0) begin
            res  = row_reg >= ROW_W'(1);
            orow = row_reg - ROW_W'(1);
            ocol = c - ADDR_W'(1);
        end else begin
            res  = row_reg >= ROW_W'(2);
            orow = row_reg - ROW_W'(2);
            ocol = ADDR_W'(w_eff - FW_W'(1));
        end
        res  = res | primed_reg;
        last = res && (orow == {1'b0, h_eff} - ROW_W'(1))
                   && ({1'b0, ocol} == w_eff - FW_W'(1));
        info.res    = res;
        info.last   = last;
        info.col    = c;
        info.border = (orow == '0) || (orow >= {1'b0, h_eff} - ROW_W'(1))
                   || (ocol == '0) || ({1'b0, ocol} >= w_eff - FW_W'(1));
        // a flush inside the frame is swallowed
        item_enter = item_acc && !(in_frame && (item_kind == KIND_FLUSH));
        item_zero  = !in_frame;
    end

    // next position
    always_comb begin
        c_inc       = {1'b0, c} + FW_W'(1);
        row_next    = row_reg;
        col_next    = c + ADDR_W'(1);
        primed_next = primed_reg | res;
        if (c_inc >= w_eff) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        if (last) begin
            row_next    = '0;
            col_next    = '0;
            primed_next = 1'b0;
        end
    end

    // registers and frame counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            row_reg          <= '0;
            col_reg          <= '0;
            primed_reg       <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_data[FW_W-1:0];
                    row_reg         <= '0;
                    col_reg         <= '0;
                    primed_reg      <= 1'b0;
                end
                CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data;
                    row_reg          <= '0;
                    col_reg          <= '0;
                    primed_reg       <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (item_enter) begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            primed_reg <= primed_next;
        end
    end

endmodule

@@ hw/rtl/lef_line_buf.sv @@
module lef_line_buf
    import lef_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_pix,
    output logic [PIX_W-1:0]  top_pix,
    output logic [PIX_W-1:0]  mid_pix
);

    logic [PIX_W-1:0] row_above_mem     [MAX_WIDTH];
    logic [PIX_W-1:0] row_two_above_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_reg;
    logic [PIX_W-1:0] mid_reg;

    // row above: read for the entering item, written with the new pixel
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_above_mem[wr_addr] <= wr_pix;
        end
        if (rd_en) begin
            mid_reg <= row_above_mem[rd_addr];
        end
    end

    // row two above: takes the pixel moving down out of the row above
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_two_above_mem[wr_addr] <= mid_reg;
        end
        if (rd_en) begin
            top_reg <= row_two_above_mem[rd_addr];
        end
    end

    assign top_pix = top_reg;
    assign mid_pix = mid_reg;

endmodule

@@ hw/rtl/lef_kernel.sv @@
module lef_kernel
    import lef_pkg::*;
(
    input  logic             border,
    input  logic [PIX_W-1:0] ctr_pix,
    input  logic [PIX_W-1:0] north_pix,
    input  logic [PIX_W-1:0] south_pix,
    input  logic [PIX_W-1:0] west_pix,
    input  logic [PIX_W-1:0] east_pix,
    output logic [PIX_W-1:0] out_pix
);

    // per channel laplacian, border pixels pass through
    always_comb begin
        out_pix = ctr_pix;
        if (!border) begin
            for (int k = 0; k < 3; k++) begin
                out_pix[k*CH_W +: CH_W] = lap_chan(ctr_pix[k*CH_W +: CH_W],
                                                   north_pix[k*CH_W +: CH_W],
                                                   south_pix[k*CH_W +: CH_W],
                                                   west_pix[k*CH_W +: CH_W],
                                                   east_pix[k*CH_W +: CH_W]);
            end
        end
    end

endmodule

@@ hw/rtl/laplacian_edge_filter_3x3_top.sv @@
// 3x3 laplacian edge filter on an rgb pixel stream in raster order. Each interior
// pixel becomes 4*centre minus its four direct neighbors per channel, clamped to
// 0..255; pixels on the first or last row or column pass through. One pixel is
// taken per clock while the output side keeps up; the rate is set by the single
// read and write port per cycle of each line buffer. A result leaves width+1
// items after its pixel entered, plus the pipeline registers (buffer read with
// the item register, then the output register loaded together with the window);
// flush items (tuser = 1) after the frame drain the
// lag, and tlast marks the last pixel of the frame. Flush items sent inside the
// frame are dropped. Writing frame_width (index 0) or frame_height (index 1)
// restarts the frame; write them only while the filter is idle. Line buffers
// need no clearing after reset.
module laplacian_edge_filter_3x3_top
    import lef_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input pixels
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tuser,   // kind
    // filtered pixels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pos_info_t        info;
    logic             item_enter;
    logic             item_zero;
    logic             s_acc;

    logic             s1_valid_reg;
    pos_info_t        s1_info_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_go;
    logic             out_free;

    logic [PIX_W-1:0] top_pix;
    logic [PIX_W-1:0] mid_pix;
    logic [PIX_W-1:0] win_top_reg;
    logic [PIX_W-1:0] win_mid_reg;
    logic [PIX_W-1:0] win_bot_reg;
    logic [PIX_W-1:0] win_west_reg;
    logic [PIX_W-1:0] res_pix;

    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    // handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s1_go     = s1_valid_reg && (out_free || !s1_info_reg.res);
    assign s_tready  = !s1_valid_reg || s1_go;
    assign s_acc     = s_tvalid && s_tready;

    lef_pos_ctrl u_pos_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_acc   (s_acc),
        .item_kind  (s_tuser),
        .item_enter (item_enter),
        .item_zero  (item_zero),
        .info       (info)
    );

    lef_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (item_enter),
        .rd_addr (info.col),
        .wr_en   (s1_go),
        .wr_addr (s1_info_reg.col),
        .wr_pix  (s1_pix_reg),
        .top_pix (top_pix),
        .mid_pix (mid_pix)
    );

    // stage 1 item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= item_enter;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_enter) begin
            s1_info_reg <= info;
            s1_pix_reg  <= item_zero ? '0 : s_tdata;
        end
    end

    // 3x3 window: centre column and west pixel kept, east pixel from the incoming column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_top_reg  <= '0;
            win_mid_reg  <= '0;
            win_bot_reg  <= '0;
            win_west_reg <= '0;
        end else if (s1_go) begin
            win_west_reg <= win_mid_reg;
            win_top_reg  <= top_pix;
            win_mid_reg  <= mid_pix;
            win_bot_reg  <= s1_pix_reg;
        end
    end

    lef_kernel u_kernel (
        .border    (s1_info_reg.border),
        .ctr_pix   (win_mid_reg),
        .north_pix (win_top_reg),
        .south_pix (win_bot_reg),
        .west_pix  (win_west_reg),
        .east_pix  (mid_pix),
        .out_pix   (res_pix)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= s1_go && s1_info_reg.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_go && s1_info_reg.res) begin
            m_tdata_reg <= res_pix;
            m_tlast_reg <= s1_info_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // a stalled stage 1 item keeps its place
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_info_reg))
        else $error("stage 1 item lost while stalled");

    // an entering item lands in stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_enter |=> s1_valid_reg)
        else $error("entering item not registered");

    // a result leaving stage 1 reaches the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_go && s1_info_reg.res |=> m_tvalid_reg)
        else $error("result dropped between stage 1 and output");

endmodule

@@ tb/laplacian_filter_checker.sv @@
`timescale 1ns / 100ps

module laplacian_filter_checker
    import lef_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tuser,   // kind
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding,
    output int                    results_seen,
    output int                    frames_seen
);

    localparam int MAX_REPORTS = 100;

    // red sits in the lowest byte of the stream data
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    typedef struct {
        rgb_t pix;
        logic frame_end;
    } filtered_t;

    // mirror of the filter state
    rgb_t              row_up1 [MAX_WIDTH];
    rgb_t              row_up2 [MAX_WIDTH];
    rgb_t              win [6];   // newest column top/mid/bottom, then the column before
    logic [ROW_W-1:0]  row_pos;
    logic [ADDR_W-1:0] col_pos;
    logic              primed;
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;
    filtered_t         filtered_q [$];

    // 4*center minus the four direct neighbors, clamped to one byte
    function automatic logic [CH_W-1:0] laplace_value(
        input logic [CH_W-1:0] ctr,
        input logic [CH_W-1:0] nb_n,
        input logic [CH_W-1:0] nb_s,
        input logic [CH_W-1:0] nb_w,
        input logic [CH_W-1:0] nb_e
    );
        int acc;
        acc = 4 * int'(ctr) - int'(nb_n) - int'(nb_s) - int'(nb_w) - int'(nb_e);
        if (acc < 0) return '0;
        if (acc > 255) return '1;
        return acc[CH_W-1:0];
    endfunction

    // advance the mirrored filter by one input transaction
    task automatic filter_step(input logic kind, input rgb_t pix_in);
        int        fw, fh, c, orow, ocol;
        logic      hit, at_end;
        rgb_t      pix, top_px, mid_px, ctr;
        filtered_t res;
        fw = (width_reg < MIN_WIDTH) ? int'(MIN_WIDTH)
           : (width_reg > MAX_WIDTH_V) ? int'(MAX_WIDTH_V) : int'(width_reg);
        fh = (height_reg < MIN_HEIGHT) ? int'(MIN_HEIGHT) : int'(height_reg);
        pix    = '0;
        at_end = 1'b0;
        // inside the frame a flush is dropped; past it any item drains the lag
        if (int'(row_pos) < fh) begin
            if (kind == KIND_FLUSH) return;
            pix = pix_in;
        end
        c = (int'(col_pos) >= fw) ? 0 : int'(col_pos);
        top_px = row_up2[c];
        mid_px = row_up1[c];

        // position of the pixel leaving the window
        if (c >= 1) begin
            hit  = (row_pos >= 1);
            orow = int'(row_pos) - 1;
            ocol = c - 1;
        end else begin
            hit  = (row_pos >= 2);
            orow = int'(row_pos) - 2;
            ocol = fw - 1;
        end
        if (primed) hit = 1'b1;

        if (hit) begin
            ctr = win[1];
            if (orow == 0 || orow >= fh - 1 || ocol == 0 || ocol >= fw - 1) begin
                res.pix = ctr;
            end else begin
                res.pix.red   = laplace_value(ctr.red, win[0].red, win[2].red,
                                              win[4].red, mid_px.red);
                res.pix.green = laplace_value(ctr.green, win[0].green, win[2].green,
                                              win[4].green, mid_px.green);
                res.pix.blue  = laplace_value(ctr.blue, win[0].blue, win[2].blue,
                                              win[4].blue, mid_px.blue);
            end
            at_end        = (orow == fh - 1) && (ocol == fw - 1);
            res.frame_end = at_end;
            filtered_q.push_back(res);
            primed = 1'b1;
        end

        // shift line buffers and window
        row_up2[c] = mid_px;
        row_up1[c] = pix;
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top_px;
        win[1] = mid_px;
        win[2] = pix;

        c++;
        if (c >= fw) begin
            c = 0;
            row_pos++;
        end
        col_pos = ADDR_W'(c);
        if (at_end) begin
            row_pos = '0;
            col_pos = '0;
            primed  = 1'b0;
        end
    endtask

    task automatic compare_field(input string what, input int want, input logic [CH_W-1:0] got);
        if (got !== want[CH_W-1:0]) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // watch the three channels at every clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (row_up1[i]) begin
                row_up1[i] = '0;
                row_up2[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            row_pos      = '0;
            col_pos      = '0;
            primed       = 1'b0;
            width_reg    = FRAME_WIDTH_RST;
            height_reg   = FRAME_HEIGHT_RST;
            filtered_q.delete();
            fail_count   = 0;
            results_seen = 0;
            frames_seen  = 0;
            outstanding  = 0;
        end else begin
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tlast === 1'b1) frames_seen++;
                if (filtered_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got rgb %h last %b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    filtered_t want;
                    rgb_t      got;
                    want = filtered_q.pop_front();
                    got  = rgb_t'(m_tdata);
                    compare_field("red", want.pix.red, got.red);
                    compare_field("green", want.pix.green, got.green);
                    compare_field("blue", want.pix.blue, got.blue);
                    compare_field("frame end", want.frame_end, {7'd0, m_tlast});
                end
            end

            // register write restarts the frame; unknown indexes are ignored
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT) begin
                    if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data[FW_W-1:0];
                    else height_reg = cfg_data;
                    row_pos = '0;
                    col_pos = '0;
                    primed  = 1'b0;
                end
            end

            if (s_tvalid && s_tready) filter_step(s_tuser, rgb_t'(s_tdata));
            outstanding = filtered_q.size();
        end
    end

endmodule

@@ tb/laplacian_edge_filter_3x3_top_tb.sv @@
`timescale 1ns / 100ps

module laplacian_edge_filter_3x3_top_tb;
    import lef_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 400;

    // pixel patterns
    localparam int STYLE_RANDOM        = 0;
    localparam int STYLE_BRIGHT_CENTER = 1;
    localparam int STYLE_DARK_CENTER   = 2;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;   // red_in, green_in, blue_in
    logic                  s_tuser   = KIND_PIXEL;   // kind
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;   // red_out, green_out, blue_out
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic steady     = 1'b0;
    int   ready_left = 0;
    int   fail_count, outstanding, results_seen, frames_seen;
    int   items_fed, items_dropped;
    int   cur_w, cur_h;

    laplacian_edge_filter_3x3_top dut (.*);

    laplacian_filter_checker u_checker (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop for a hung run
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // idle length: mostly none or short, sometimes long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(9, 24);
    endfunction

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // red follows the pattern, green its inverse, blue is random
    function automatic logic [PIX_W-1:0] pixel_at(input int style, input int r, input int c);
        logic [CH_W-1:0] bright;
        if (style == STYLE_RANDOM) return {rand_chan(), rand_chan(), rand_chan()};
        bright = (((r + c) % 2 == 0) == (style == STYLE_BRIGHT_CENTER)) ? '1 : '0;
        return {rand_chan(), ~bright, bright};
    endfunction

    // receiver stalls in random runs
    always @(posedge aclk) begin
        if (steady) begin
            m_tready   <= 1'b1;
            ready_left <= 0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_tready) begin
            m_tready   <= 1'b0;
            ready_left <= idle_len();
        end else begin
            m_tready   <= 1'b1;
            ready_left <= $urandom_range(0, 15);
        end
    end

    task automatic push_item(input logic kind, input logic [PIX_W-1:0] pix);
        int gap;
        bit took;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pix;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit hold);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        if (!hold) cfg_valid <= 1'b0;
    endtask

    // stop sending until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // new frame geometry, written only with the filter idle
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] wval,
                                input logic [CFG_DATA_W-1:0] hval);
        int wv;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write(CFG_FRAME_WIDTH, wval, 1'b1);
        cfg_write(CFG_FRAME_HEIGHT, hval, 1'b0);
        wv    = int'(wval[FW_W-1:0]);
        cur_w = (wv < 3) ? 3 : (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
        cur_h = (hval < 3) ? 3 : int'(hval);
    endtask

    // one frame of pixels then the drain items; cut < 0 sends the whole frame, else it stops at pixel cut with no drain
    task automatic run_frame(input int style, input int cut, input int noise_pct);
        int n;
        for (n = 0; n < cur_w * cur_h; n++) begin
            if (n == cut) return;
            if ($urandom_range(0, 99) < noise_pct) begin
                push_item(KIND_FLUSH, pixel_at(STYLE_RANDOM, 0, 0));
                items_dropped++;
            end
            if ($urandom_range(0, 299) == 0) wait_drained();
            push_item(KIND_PIXEL, pixel_at(style, n / cur_w, n % cur_w));
            items_fed++;
        end
        // a pixel past the frame drains like a flush
        for (n = 0; n <= cur_w; n++) begin
            push_item($urandom_range(0, 1) ? KIND_FLUSH : KIND_PIXEL,
                      pixel_at(STYLE_RANDOM, 0, 0));
            items_fed++;
        end
    endtask

    // stimulus and verdict
    initial begin
        int start, cut, sel;
        logic [CFG_DATA_W-1:0] wval, hval;
        bit need_cfg;

        items_fed     = 0;
        items_dropped = 0;
        cur_w         = int'(FRAME_WIDTH_RST);
        cur_h         = int'(FRAME_HEIGHT_RST);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: flush inside the frame, then part of the first rows
        push_item(KIND_FLUSH, pixel_at(STYLE_RANDOM, 0, 0));
        items_dropped++;
        run_frame(STYLE_RANDOM, 310, 0);

        // smallest frame, plain and with in-frame flushes
        set_geometry(12'd3, 12'd3);
        run_frame(STYLE_BRIGHT_CENTER, -1, 0);
        run_frame(STYLE_DARK_CENTER, -1, 30);

        // width beyond the line buffer, cut once the first row starts to come out
        set_geometry(12'd2047, 12'd0);
        run_frame(STYLE_RANDOM, 1040, 1);

        // tallest frame, cut short; unknown register indexes change nothing
        set_geometry(12'd2, 12'd4095);
        run_frame(STYLE_RANDOM, 90, 2);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write(CFG_IDX_W'(2), 12'hFFF, 1'b1);
        cfg_write(CFG_IDX_W'(255), 12'h000, 1'b0);
        repeat (30) begin
            push_item(KIND_PIXEL, pixel_at(STYLE_RANDOM, 0, 0));
            items_fed++;
        end

        // width with a bit above the register field set
        set_geometry(12'h803, 12'd5);
        run_frame(STYLE_RANDOM, -1, 0);

        // random frames, some cut short, some back to back
        start    = items_fed;
        need_cfg = 1'b1;
        while (items_fed - start < RANDOM_ITEMS) begin
            steady <= ($urandom_range(0, 4) == 0);
            if (need_cfg || $urandom_range(0, 2) == 0) begin
                sel  = $urandom_range(0, 19);
                wval = (sel == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                     : (sel == 1) ? (12'h800 | CFG_DATA_W'($urandom_range(3, 10)))
                     : CFG_DATA_W'($urandom_range(3, 12));
                hval = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                     : CFG_DATA_W'($urandom_range(3, 8));
                set_geometry(wval, hval);
            end
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cur_w * cur_h - 1) : -1;
            run_frame(STYLE_RANDOM, cut, 4);
            need_cfg = (cut >= 0);
        end

        // drain and let the pipeline settle
        steady <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        $display("summary: %0d items streamed, %0d in-frame flushes dropped",
                 items_fed, items_dropped);
        $display("summary: %0d results checked, %0d frames closed, widths 3 to 1024",
                 results_seen, frames_seen);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
